// ===== src/i2cmps_pkg.sv =====
`default_nettype none

package i2cmps_pkg;

   // bus command codes, same encoding as req_type
   typedef enum logic [2:0] {
      CMD_START    = 3'd0,
      CMD_STOP     = 3'd1,
      CMD_WRITE    = 3'd2,
      CMD_READ     = 3'd3,
      CMD_SEND_ACK = 3'd4,
      CMD_READ_ACK = 3'd5
   } cmd_type;

   // one decoded command waiting for the back end
   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] write_data;
      logic       ack_level;
      logic [7:0] bus_sda_bits;
   } cmd_entry_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_HOLD,
      BACK_SEND
   } back_state_type;

   localparam logic [15:0] HOLD_TICKS_RESET = 16'd10;

   // read byte opens with an extra sda release step before the bit steps
   localparam logic [1:0] SUB_FIRST   = 2'd0;
   localparam logic [1:0] SUB_RELEASE = 2'd3;
   localparam logic [1:0] SUB_BIT_END = 2'd2;
   localparam logic [2:0] BIT_FIRST   = 3'd0;
   localparam logic [2:0] BIT_LAST    = 3'd7;

endpackage

`default_nettype wire

// ===== src/i2cmps_req_if.sv =====
`default_nettype none

interface i2cmps_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] req_type;
   logic [7:0] write_data;
   logic       ack_level;
   logic [7:0] bus_sda_bits;

   modport source (
      output valid, req_type, write_data, ack_level, bus_sda_bits,
      input  ready
   );

   modport sink (
      input  valid, req_type, write_data, ack_level, bus_sda_bits,
      output ready
   );
endinterface

`default_nettype wire

// ===== src/i2cmps_rsp_if.sv =====
`default_nettype none

interface i2cmps_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_level;
   logic       sda_level;
   logic       sample_phase;
   logic [7:0] read_byte;
   logic       ack_seen;
   logic       last_phase;

   modport source (
      output valid, scl_level, sda_level, sample_phase, read_byte, ack_seen, last_phase,
      input  ready
   );

   modport sink (
      input  valid, scl_level, sda_level, sample_phase, read_byte, ack_seen, last_phase,
      output ready
   );
endinterface

`default_nettype wire

// ===== src/i2cmps_front.sv =====
`default_nettype none

module i2cmps_front (
   i2cmps_req_if.sink             req_bus,
   input  wire logic              q_full,
   output logic                   q_push,
   output i2cmps_pkg::cmd_entry_type q_entry
);

   logic known;

   // unknown codes are taken and dropped
   always_comb begin
      known = 1'b0;
      unique case (i2cmps_pkg::cmd_type'(req_bus.req_type))
         i2cmps_pkg::CMD_START, i2cmps_pkg::CMD_STOP, i2cmps_pkg::CMD_WRITE,
         i2cmps_pkg::CMD_READ, i2cmps_pkg::CMD_SEND_ACK,
         i2cmps_pkg::CMD_READ_ACK: known = 1'b1;
         default: known = 1'b0;
      endcase
   end

   assign req_bus.ready = !q_full;
   assign q_push        = req_bus.valid && !q_full && known;

   always_comb begin
      q_entry.cmd          = i2cmps_pkg::cmd_type'(req_bus.req_type);
      q_entry.write_data   = req_bus.write_data;
      q_entry.ack_level    = req_bus.ack_level;
      q_entry.bus_sda_bits = req_bus.bus_sda_bits;
   end

endmodule

`default_nettype wire

// ===== src/i2cmps_queue.sv =====
`default_nettype none

module i2cmps_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire i2cmps_pkg::cmd_entry_type push_entry,
   output logic                           full,
   input  wire logic                      pop,
   output logic                           head_valid,
   output i2cmps_pkg::cmd_entry_type      head_entry
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   i2cmps_pkg::cmd_entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== src/i2cmps_back.sv =====
`default_nettype none

module i2cmps_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic [15:0]               hold_ticks,
   input  wire logic                      q_valid,
   input  wire i2cmps_pkg::cmd_entry_type q_entry,
   output logic                           q_pop,
   i2cmps_rsp_if.source                   rsp_bus
);

   i2cmps_pkg::back_state_type state_ff, state_in;
   i2cmps_pkg::cmd_entry_type  cur_ff, cur_in;
   logic [1:0]  sub_ff, sub_in;
   logic [2:0]  bit_ff, bit_in;
   logic [15:0] hold_cnt_ff, hold_cnt_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_scl_ff, rsp_scl_in;
   logic        rsp_sda_ff, rsp_sda_in;
   logic        rsp_smp_ff, rsp_smp_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic        rsp_ack_ff, rsp_ack_in;
   logic        rsp_last_ff, rsp_last_in;

   // levels of the phase at the current step
   logic       ph_scl, ph_sda, ph_smp, ph_ack, ph_last, wbit, out_free;
   logic [7:0] ph_byte;

   assign wbit     = cur_ff.write_data[3'd7 - bit_ff];
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      ph_scl  = scl_ff;
      ph_sda  = sda_ff;
      ph_smp  = 1'b0;
      ph_byte = 8'd0;
      ph_ack  = 1'b0;
      ph_last = 1'b0;
      unique case (cur_ff.cmd)
         i2cmps_pkg::CMD_START: begin
            unique case (sub_ff)
               2'd0: ph_scl = 1'b1;
               2'd1: begin ph_scl = 1'b1; ph_sda = 1'b1; end
               2'd2: begin ph_scl = 1'b1; ph_sda = 1'b0; end
               default: begin ph_scl = 1'b0; ph_last = 1'b1; end
            endcase
         end
         i2cmps_pkg::CMD_STOP: begin
            unique case (sub_ff)
               2'd0: ph_sda = 1'b0;
               2'd1: begin ph_scl = 1'b1; ph_sda = 1'b0; end
               default: begin ph_scl = 1'b1; ph_sda = 1'b1; ph_last = 1'b1; end
            endcase
         end
         i2cmps_pkg::CMD_WRITE: begin
            ph_sda = wbit;
            unique case (sub_ff)
               2'd0: ;
               2'd1: ph_scl = 1'b1;
               default: begin ph_scl = 1'b0; ph_last = (bit_ff == i2cmps_pkg::BIT_LAST); end
            endcase
         end
         i2cmps_pkg::CMD_READ: begin
            ph_sda = 1'b1;
            unique case (sub_ff)
               2'd0: ph_scl = 1'b1;
               2'd1: begin ph_scl = 1'b1; ph_smp = 1'b1; end
               2'd2: begin
                  ph_scl = 1'b0;
                  if (bit_ff == i2cmps_pkg::BIT_LAST) begin
                     ph_last = 1'b1;
                     ph_byte = cur_ff.bus_sda_bits;
                  end
               end
               default: ;  // release step keeps scl
            endcase
         end
         i2cmps_pkg::CMD_SEND_ACK: begin
            ph_sda = cur_ff.ack_level;
            unique case (sub_ff)
               2'd0: ;
               2'd1: ph_scl = 1'b1;
               default: begin ph_scl = 1'b0; ph_last = 1'b1; end
            endcase
         end
         default: begin  // read ack
            ph_sda = 1'b1;
            unique case (sub_ff)
               2'd0: ;
               2'd1: ph_scl = 1'b1;
               2'd2: begin ph_scl = 1'b1; ph_smp = 1'b1; end
               default: begin
                  ph_scl  = 1'b0;
                  ph_ack  = cur_ff.bus_sda_bits[7];
                  ph_last = 1'b1;
               end
            endcase
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      sub_in       = sub_ff;
      bit_in       = bit_ff;
      hold_cnt_in  = hold_cnt_ff;
      scl_in       = scl_ff;
      sda_in       = sda_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_scl_in   = rsp_scl_ff;
      rsp_sda_in   = rsp_sda_ff;
      rsp_smp_in   = rsp_smp_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_ack_in   = rsp_ack_ff;
      rsp_last_in  = rsp_last_ff;
      q_pop        = 1'b0;
      unique case (state_ff)
         i2cmps_pkg::BACK_IDLE: begin
            if (q_valid) begin
               q_pop       = 1'b1;
               cur_in      = q_entry;
               sub_in      = (q_entry.cmd == i2cmps_pkg::CMD_READ) ?
                             i2cmps_pkg::SUB_RELEASE : i2cmps_pkg::SUB_FIRST;
               bit_in      = i2cmps_pkg::BIT_FIRST;
               hold_cnt_in = hold_ticks;
               state_in    = i2cmps_pkg::BACK_HOLD;
            end
         end
         i2cmps_pkg::BACK_HOLD: begin
            if (hold_cnt_ff <= 16'd1) begin
               state_in = i2cmps_pkg::BACK_SEND;
            end else begin
               hold_cnt_in = hold_cnt_ff - 16'd1;
            end
         end
         i2cmps_pkg::BACK_SEND: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_scl_in   = ph_scl;
               rsp_sda_in   = ph_sda;
               rsp_smp_in   = ph_smp;
               rsp_byte_in  = ph_byte;
               rsp_ack_in   = ph_ack;
               rsp_last_in  = ph_last;
               scl_in       = ph_scl;
               sda_in       = ph_sda;
               if (ph_last) begin
                  state_in = i2cmps_pkg::BACK_IDLE;
               end else begin
                  hold_cnt_in = hold_ticks;
                  state_in    = i2cmps_pkg::BACK_HOLD;
                  // bit commands wrap after the scl low step, release step wraps to 0
                  if ((cur_ff.cmd == i2cmps_pkg::CMD_WRITE ||
                       cur_ff.cmd == i2cmps_pkg::CMD_READ) &&
                      sub_ff == i2cmps_pkg::SUB_BIT_END) begin
                     sub_in = i2cmps_pkg::SUB_FIRST;
                     bit_in = 3'(bit_ff + 3'd1);
                  end else begin
                     sub_in = 2'(sub_ff + 2'd1);
                  end
               end
            end
         end
         default: state_in = i2cmps_pkg::BACK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= i2cmps_pkg::BACK_IDLE;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      sub_ff      <= sub_in;
      bit_ff      <= bit_in;
      hold_cnt_ff <= hold_cnt_in;
      rsp_scl_ff  <= rsp_scl_in;
      rsp_sda_ff  <= rsp_sda_in;
      rsp_smp_ff  <= rsp_smp_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_ack_ff  <= rsp_ack_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.scl_level    = rsp_scl_ff;
   assign rsp_bus.sda_level    = rsp_sda_ff;
   assign rsp_bus.sample_phase = rsp_smp_ff;
   assign rsp_bus.read_byte    = rsp_byte_ff;
   assign rsp_bus.ack_seen     = rsp_ack_ff;
   assign rsp_bus.last_phase   = rsp_last_ff;

endmodule

`default_nettype wire

// ===== src/i2c_master_phase_sequencer.sv =====
// channel   dir  handshake         payload
// req_bus   in   valid / ready     req_type, write_data, ack_level, bus_sda_bits
// rsp_bus   out  valid / ready     scl_level, sda_level, sample_phase, read_byte,
//                                  ack_seen, last_phase (one transaction per line phase)
// csr       in   csr_wr_en         csr_wr_data = phase hold in timebase ticks
//
// each phase is held by the per-phase hold counter in the back end before it goes
// out on rsp_bus; phases: start 4, stop 3, write 24, read 25, acks 3 / 4
// unknown command codes are taken and yield no transaction
// reset is synchronous; both lines come up released high, hold comes up at 10
// the command queue lets the front keep taking transactions while the back end
// holds a phase or waits on a stalled rsp_bus
`default_nettype none

module i2c_master_phase_sequencer #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic  clock,
   input  wire logic  reset,
   i2cmps_req_if.sink   req_bus,
   i2cmps_rsp_if.source rsp_bus,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   // phase hold register
   logic [15:0] hold_ticks_ff, hold_ticks_in;

   assign hold_ticks_in = csr_wr_en ? csr_wr_data : hold_ticks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ticks_ff <= i2cmps_pkg::HOLD_TICKS_RESET;
      end else begin
         hold_ticks_ff <= hold_ticks_in;
      end
   end

   // front: decode and drop unknown codes
   logic                      q_push, q_full, q_pop, q_valid;
   i2cmps_pkg::cmd_entry_type q_push_entry, q_head_entry;

   i2cmps_front u_front (
      .req_bus (req_bus),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_entry (q_push_entry)
   );

   // command queue between front and back
   i2cmps_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_entry (q_head_entry)
   );

   // back: phase sequencer with line state and output register
   i2cmps_back u_back (
      .clock      (clock),
      .reset      (reset),
      .hold_ticks (hold_ticks_ff),
      .q_valid    (q_valid),
      .q_entry    (q_head_entry),
      .q_pop      (q_pop),
      .rsp_bus    (rsp_bus)
   );

endmodule

`default_nettype wire

// ===== sim/i2c_master_phase_sequencer_test.sv =====
`timescale 1ns / 1ps

module i2c_master_phase_sequencer_test;

   // codes outside the command set, taken by the block without any line phase
   localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
   localparam logic [2:0] CMD_UNUSED_7 = 3'd7;

   localparam int CYCLE_LIMIT  = 1_500_000;
   localparam int DRAIN_CYCLES = 64;
   localparam int IDLE_PERCENT = 20;

   // one bus command as it goes onto req_bus
   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] wdata;
      logic       ack_level;
      logic [7:0] sda_bits;
   } bus_cmd_type;

   // one line phase as it should show up on rsp_bus
   typedef struct packed {
      logic       scl;
      logic       sda;
      logic       sample;
      logic [7:0] rbyte;
      logic       ack;
      logic       last;
   } line_phase_type;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   i2cmps_req_if req_bus ();
   i2cmps_rsp_if rsp_bus ();

   i2c_master_phase_sequencer DUT (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   bus_cmd_type    pending_cmds[$];
   line_phase_type line_phases_due[$];
   bus_cmd_type    cmd_on_bus;

   // predicted line drives, both released high out of reset
   logic bus_scl;
   logic bus_sda;

   logic no_idle;
   int   mismatches;
   int   cycles;

   always #5 clock = ~clock;

   // -----------------------------------------------------------------
   // line phase predictor
   // -----------------------------------------------------------------

   // record the current line drives as one expected phase
   task automatic push_phase(input logic sample, input logic [7:0] rbyte,
                             input logic ack, input logic last);
      line_phase_type p;
      p.scl    = bus_scl;
      p.sda    = bus_sda;
      p.sample = sample;
      p.rbyte  = rbyte;
      p.ack    = ack;
      p.last   = last;
      line_phases_due.push_back(p);
   endtask

   // expand one accepted command into the run of line phases it produces
   task automatic predict_line_phases(input bus_cmd_type c);
      logic [7:0] shift;
      int         i;
      shift = 8'h00;
      case (c.kind)
         i2cmps_pkg::CMD_START: begin
            // both lines high, then sda falls while scl is high, then scl falls
            bus_scl = 1'b1; push_phase(1'b0, 8'h00, 1'b0, 1'b0);
            bus_sda = 1'b1; push_phase(1'b0, 8'h00, 1'b0, 1'b0);
            bus_sda = 1'b0; push_phase(1'b0, 8'h00, 1'b0, 1'b0);
            bus_scl = 1'b0; push_phase(1'b0, 8'h00, 1'b0, 1'b1);
         end
         i2cmps_pkg::CMD_STOP: begin
            // sda low, scl up, then sda rises while scl is high
            bus_sda = 1'b0; push_phase(1'b0, 8'h00, 1'b0, 1'b0);
            bus_scl = 1'b1; push_phase(1'b0, 8'h00, 1'b0, 1'b0);
            bus_sda = 1'b1; push_phase(1'b0, 8'h00, 1'b0, 1'b1);
         end
         i2cmps_pkg::CMD_WRITE: begin
            // msb first: data, clock high, clock low
            for (i = 0; i < 8; i++) begin
               bus_sda = c.wdata[7 - i]; push_phase(1'b0, 8'h00, 1'b0, 1'b0);
               bus_scl = 1'b1;           push_phase(1'b0, 8'h00, 1'b0, 1'b0);
               bus_scl = 1'b0;           push_phase(1'b0, 8'h00, 1'b0, i == 7);
            end
         end
         i2cmps_pkg::CMD_READ: begin
            // release sda once, then clock in eight bits off the bus
            bus_sda = 1'b1; push_phase(1'b0, 8'h00, 1'b0, 1'b0);
            for (i = 0; i < 8; i++) begin
               bus_scl = 1'b1; push_phase(1'b0, 8'h00, 1'b0, 1'b0);
               shift[7 - i] = c.sda_bits[7 - i];
               // sampling leaves the drives as they are
               push_phase(1'b1, 8'h00, 1'b0, 1'b0);
               // assembled byte only shows on the closing phase
               bus_scl = 1'b0;
               push_phase(1'b0, (i == 7) ? shift : 8'h00, 1'b0, i == 7);
            end
         end
         i2cmps_pkg::CMD_SEND_ACK: begin
            bus_sda = c.ack_level; push_phase(1'b0, 8'h00, 1'b0, 1'b0);
            bus_scl = 1'b1;        push_phase(1'b0, 8'h00, 1'b0, 1'b0);
            bus_scl = 1'b0;        push_phase(1'b0, 8'h00, 1'b0, 1'b1);
         end
         i2cmps_pkg::CMD_READ_ACK: begin
            // ack level comes from the top bit of the bus field
            bus_sda = 1'b1; push_phase(1'b0, 8'h00, 1'b0, 1'b0);
            bus_scl = 1'b1; push_phase(1'b0, 8'h00, 1'b0, 1'b0);
            push_phase(1'b1, 8'h00, 1'b0, 1'b0);
            bus_scl = 1'b0; push_phase(1'b0, 8'h00, c.sda_bits[7], 1'b1);
         end
         default: begin
            // unused codes: no phase, drives untouched
         end
      endcase
   endtask

   // -----------------------------------------------------------------
   // command driver
   // -----------------------------------------------------------------

   // predicts at the accepting edge, then offers the next queued command
   always @(posedge clock) begin : req_driver
      logic offer;
      offer = 1'b0;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_line_phases(cmd_on_bus);
         end
         if (!req_bus.valid || req_bus.ready) begin
            // random gaps between commands unless the quiet stretch is on
            if (pending_cmds.size() != 0 &&
                (no_idle || $urandom_range(99) >= IDLE_PERCENT)) begin
               cmd_on_bus = pending_cmds.pop_front();
               offer = 1'b1;
               req_bus.req_type     <= cmd_on_bus.kind;
               req_bus.write_data   <= cmd_on_bus.wdata;
               req_bus.ack_level    <= cmd_on_bus.ack_level;
               req_bus.bus_sda_bits <= cmd_on_bus.sda_bits;
            end
            req_bus.valid <= offer;
         end
      end
   end

   // -----------------------------------------------------------------
   // line phase monitor
   // -----------------------------------------------------------------

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : rsp_monitor
      line_phase_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (line_phases_due.size() == 0) begin
               $display("%0t: unexpected line phase, expected none, actual scl %0b sda %0b",
                        $time, rsp_bus.scl_level, rsp_bus.sda_level);
               mismatches++;
            end else begin
               want = line_phases_due.pop_front();
               check_field("scl_level",    8'(want.scl),    8'(rsp_bus.scl_level));
               check_field("sda_level",    8'(want.sda),    8'(rsp_bus.sda_level));
               check_field("sample_phase", 8'(want.sample), 8'(rsp_bus.sample_phase));
               check_field("read_byte",    want.rbyte,      rsp_bus.read_byte);
               check_field("ack_seen",     8'(want.ack),    8'(rsp_bus.ack_seen));
               check_field("last_phase",   8'(want.last),   8'(rsp_bus.last_phase));
            end
         end
         // back pressure at random, none during the quiet stretch
         rsp_bus.ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // -----------------------------------------------------------------
   // watchdog
   // -----------------------------------------------------------------

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // -----------------------------------------------------------------
   // stimulus
   // -----------------------------------------------------------------

   // a command of the given kind with every other field random
   function automatic bus_cmd_type random_cmd(input logic [2:0] kind);
      bus_cmd_type c;
      c.kind      = kind;
      c.wdata     = 8'($urandom);
      c.ack_level = 1'($urandom);
      c.sda_bits  = 8'($urandom);
      return c;
   endfunction

   task automatic queue_cmd(input logic [2:0] kind, input logic [7:0] wdata,
                            input logic ack_level, input logic [7:0] sda_bits);
      bus_cmd_type c;
      c.kind      = kind;
      c.wdata     = wdata;
      c.ack_level = ack_level;
      c.sda_bits  = sda_bits;
      pending_cmds.push_back(c);
   endtask

   // a well formed transfer: start, address, ack, one to four data bytes, mostly a stop
   task automatic queue_transfer(inout int issued);
      bus_cmd_type addr;
      int          nbytes;
      int          k;
      pending_cmds.push_back(random_cmd(i2cmps_pkg::CMD_START));
      addr = random_cmd(i2cmps_pkg::CMD_WRITE);
      pending_cmds.push_back(addr);
      pending_cmds.push_back(random_cmd(i2cmps_pkg::CMD_READ_ACK));
      issued += 3;
      nbytes = $urandom_range(1, 4);
      for (k = 0; k < nbytes; k++) begin
         if (addr.wdata[0]) begin
            // master read: byte in, then ack from us, not ack on the final byte, one in ten levels random
            pending_cmds.push_back(random_cmd(i2cmps_pkg::CMD_READ));
            queue_cmd(i2cmps_pkg::CMD_SEND_ACK, 8'($urandom),
                      ($urandom_range(9) == 0) ? 1'($urandom) : (k == nbytes - 1),
                      8'($urandom));
         end else begin
            pending_cmds.push_back(random_cmd(i2cmps_pkg::CMD_WRITE));
            pending_cmds.push_back(random_cmd(i2cmps_pkg::CMD_READ_ACK));
         end
         issued += 2;
      end
      // mostly a stop, sometimes a repeated start into the next transfer
      if ($urandom_range(99) < 80) begin
         pending_cmds.push_back(random_cmd(i2cmps_pkg::CMD_STOP));
         issued++;
      end
   endtask

   // mostly proper transfers, the rest loose commands in any order
   task automatic queue_random(input int count);
      int          issued;
      bus_cmd_type c;
      issued = 0;
      while (issued < count) begin
         if ($urandom_range(99) < 75) begin
            queue_transfer(issued);
         end else begin
            c = random_cmd(3'($urandom_range(7)));
            pending_cmds.push_back(c);
            // unused codes are ignored by the block and do not count
            if (c.kind != CMD_UNUSED_6 && c.kind != CMD_UNUSED_7) begin
               issued++;
            end
         end
      end
   endtask

   // block until every command is taken and every phase seen, then settle
   task automatic wait_drained;
      do begin
         @(posedge clock);
      end while (pending_cmds.size() != 0 || req_bus.valid || line_phases_due.size() != 0);
      // let the block go quiet before the hold changes
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_hold(input logic [15:0] ticks);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= ticks;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      clock                = 1'b0;
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_wr_data          = 16'h0000;
      req_bus.valid        = 1'b0;
      req_bus.req_type     = i2cmps_pkg::CMD_START;
      req_bus.write_data   = 8'h00;
      req_bus.ack_level    = 1'b0;
      req_bus.bus_sda_bits = 8'h00;
      rsp_bus.ready        = 1'b0;
      bus_scl              = 1'b1;
      bus_sda              = 1'b1;
      no_idle              = 1'b0;
      mismatches           = 0;
      cycles               = 0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed pass at the reset hold
      queue_cmd(i2cmps_pkg::CMD_START,    8'h00, 1'b0, 8'h00);
      queue_cmd(i2cmps_pkg::CMD_WRITE,    8'h00, 1'b1, 8'hff);
      queue_cmd(i2cmps_pkg::CMD_WRITE,    8'hff, 1'b0, 8'h00);
      queue_cmd(i2cmps_pkg::CMD_WRITE,    8'ha5, 1'b0, 8'h00);
      queue_cmd(i2cmps_pkg::CMD_WRITE,    8'h80, 1'b0, 8'h00);
      queue_cmd(i2cmps_pkg::CMD_WRITE,    8'h01, 1'b0, 8'h00);
      queue_cmd(i2cmps_pkg::CMD_READ,     8'hff, 1'b1, 8'h00);
      queue_cmd(i2cmps_pkg::CMD_READ,     8'h00, 1'b0, 8'hff);
      queue_cmd(i2cmps_pkg::CMD_READ,     8'h00, 1'b0, 8'h5a);
      queue_cmd(i2cmps_pkg::CMD_READ,     8'h00, 1'b0, 8'h81);
      queue_cmd(i2cmps_pkg::CMD_SEND_ACK, 8'h00, 1'b0, 8'hff);
      queue_cmd(i2cmps_pkg::CMD_SEND_ACK, 8'hff, 1'b1, 8'h00);
      // ack seen follows bit 7 only
      queue_cmd(i2cmps_pkg::CMD_READ_ACK, 8'h00, 1'b0, 8'h80);
      queue_cmd(i2cmps_pkg::CMD_READ_ACK, 8'hff, 1'b1, 8'h7f);
      queue_cmd(i2cmps_pkg::CMD_STOP,     8'hff, 1'b1, 8'hff);
      // unused codes between real commands must leave the lines alone
      queue_cmd(CMD_UNUSED_6,             8'hff, 1'b1, 8'hff);
      queue_cmd(CMD_UNUSED_7,             8'h00, 1'b0, 8'h00);
      queue_cmd(i2cmps_pkg::CMD_START,    8'h00, 1'b0, 8'h00);
      queue_cmd(CMD_UNUSED_7,             8'hff, 1'b1, 8'hff);
      queue_cmd(i2cmps_pkg::CMD_STOP,     8'h00, 1'b0, 8'h00);
      queue_cmd(i2cmps_pkg::CMD_STOP,     8'h00, 1'b0, 8'h00);
      queue_cmd(i2cmps_pkg::CMD_START,    8'h00, 1'b0, 8'h00);
      queue_cmd(i2cmps_pkg::CMD_START,    8'h00, 1'b0, 8'h00);
      wait_drained();

      // zero hold is accepted as written
      write_hold(16'd0);
      queue_random(35);
      wait_drained();

      // longest hold, one short command only
      write_hold(16'hffff);
      pending_cmds.push_back(random_cmd(i2cmps_pkg::CMD_SEND_ACK));
      wait_drained();

      // shortest hold with both sides running flat out
      write_hold(16'd1);
      no_idle = 1'b1;
      queue_random(30);
      wait_drained();
      no_idle = 1'b0;

      write_hold(16'($urandom_range(2, 6)));
      queue_random(50);
      wait_drained();

      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
